// ----- design/slkt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted leaf key table package
// Shared sizes, command and status codes, sequencer states and the word types of the
// sorted leaf core.
// ----------------------------------------------------------------------------
package slkt_pkg;

    // Leaf geometry
    localparam int MAX_CELLS    = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_W        = 32;
    localparam int CELL_W       = KEY_W + PAYLOAD_BITS;
    localparam int IDX_W        = $clog2(MAX_CELLS);
    localparam int CNT_W        = $clog2(MAX_CELLS + 1);

    // Fixed field widths of the stream words
    localparam int IN_KEY_W   = 32;
    localparam int IN_PL_W    = 32;
    localparam int IN_IDX_W   = 4;
    localparam int OUT_POS_W  = 5;
    localparam int OUT_CNT_W  = 5;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 80;

    typedef enum logic [1:0] {
        CMD_FIND   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2
    } slkt_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } slkt_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_SHIFT,
        ST_PLACE,
        ST_READ,
        ST_DONE
    } slkt_state_t;

    // One accepted command word
    typedef struct packed {
        logic [1:0]          cmd;
        logic [IN_KEY_W-1:0] key;
        logic [IN_PL_W-1:0]  payload;
        logic [IN_IDX_W-1:0] cell_index;
    } slkt_item_t;

    // One result word
    typedef struct packed {
        logic [1:0]           status;
        logic [OUT_POS_W-1:0] position;
        logic                 matched;
        logic [KEY_W-1:0]     key_out;
        logic [IN_PL_W-1:0]   payload_out;
        logic [OUT_CNT_W-1:0] cell_count;
    } slkt_result_t;

endpackage
`default_nettype wire

// ----- design/slkt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module slkt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ----- design/slkt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted leaf sequencer
// Runs the binary search, the upward shift and the cell write against the
// cell RAM, and builds one result word per command.
// ----------------------------------------------------------------------------
module slkt_ctrl
    import slkt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire slkt_item_t   in_item,
    output logic              res_valid,
    input  wire logic         res_ready,
    output slkt_result_t      res
);

    slkt_state_t  state_reg, state_next;
    slkt_item_t   item_reg, item_next;
    slkt_result_t res_reg, res_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hiex_reg, hiex_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_addr_reg, pend_addr_next;

    // RAM port signals
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic [KEY_W-1:0]  rd_key;
    logic [CNT_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid_calc;

    slkt_ram #(
        .WIDTH(CELL_W),
        .DEPTH(MAX_CELLS)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key   = rd_data[KEY_W-1:0];
    // Midpoint of the half-open range [lo, hiex)
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hiex_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid_calc = IDX_W'(mid_sum >> 1);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        lo_reg        <= lo_next;
        hiex_reg      <= hiex_next;
        hit_reg       <= hit_next;
        mid_reg       <= mid_next;
        ptr_reg       <= ptr_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hiex_next      = hiex_reg;
        hit_next       = hit_reg;
        mid_next       = mid_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data;
        rd_addr        = mid_calc;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                rd_addr  = IDX_W'(in_item.cell_index);
                if (in_valid) begin
                    item_next = in_item;
                    lo_next   = '0;
                    hiex_next = count_reg;
                    hit_next  = 1'b0;
                    res_next  = '0;
                    res_next.cell_count = OUT_CNT_W'(count_reg);
                    case (slkt_cmd_t'(in_item.cmd))
                        CMD_FIND, CMD_INSERT: begin
                            state_next = ST_SEARCH;
                        end
                        CMD_READ: begin
                            res_next.position = OUT_POS_W'(in_item.cell_index);
                            if (32'(in_item.cell_index) < 32'(count_reg)) begin
                                state_next = ST_READ;
                            end else begin
                                res_next.status = STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                        end
                        default: begin
                            // unused command: report the count only
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                if (lo_reg < hiex_reg) begin
                    rd_addr    = mid_calc;
                    mid_next   = mid_calc;
                    state_next = ST_COMPARE;
                end else begin
                    res_next.position = OUT_POS_W'(lo_reg);
                    res_next.matched  = hit_reg;
                    if (slkt_cmd_t'(item_reg.cmd) == CMD_INSERT) begin
                        if (count_reg == CNT_W'(MAX_CELLS)) begin
                            res_next.status = STAT_FULL;
                            state_next      = ST_DONE;
                        end else begin
                            ptr_next   = IDX_W'(count_reg);
                            pend_next  = 1'b0;
                            state_next = ST_SHIFT;
                        end
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_COMPARE: begin
                // narrow the range around the probed key
                if (rd_key == item_reg.key) begin
                    hit_next  = 1'b1;
                    lo_next   = CNT_W'(mid_reg);
                    hiex_next = CNT_W'(mid_reg);
                end else if (rd_key < item_reg.key) begin
                    lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                end else begin
                    hiex_next = CNT_W'(mid_reg);
                end
                state_next = ST_SEARCH;
            end

            ST_SHIFT: begin
                // write back the cell read last cycle one slot higher
                wr_en   = pend_reg;
                wr_addr = pend_addr_reg;
                wr_data = rd_data;
                if (CNT_W'(ptr_reg) > lo_reg) begin
                    rd_addr        = ptr_reg - IDX_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg;
                    ptr_next       = ptr_reg - IDX_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_PLACE;
                    end
                end
            end

            ST_PLACE: begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(lo_reg);
                wr_data    = {PAYLOAD_BITS'(item_reg.payload), item_reg.key};
                count_next = count_reg + CNT_W'(1);
                res_next.cell_count = OUT_CNT_W'(count_reg + CNT_W'(1));
                state_next = ST_DONE;
            end

            ST_READ: begin
                res_next.key_out     = rd_key;
                res_next.payload_out = IN_PL_W'(rd_data[CELL_W-1:KEY_W]);
                state_next           = ST_DONE;
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule
`default_nettype wire

// ----- design/sorted_leaf_key_table_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted leaf key table core
// One B-tree leaf holding key/payload cells in ascending key order, with
// find, insert and read commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream, one word each, cmd in s_tuser. Each
//   command yields exactly one result word on the m_ stream.
//   The core takes one command at a time. A find runs S binary search probes
//   (at most log2(count)+1); each probe is a RAM read and a compare. An
//   insert moves each cell at or above the position up one slot (count -
//   position cells), streaming through the single cell RAM one entry per
//   cycle, then writes the new cell. A read fetches the indexed cell from
//   the RAM.
//   Results sit in an output register; a new command is taken while the
//   previous result waits. If the receiver stalls, the next result holds in
//   the sequencer and no further command is accepted until it moves.
//   Reset clears the cell count and both handshakes; cell contents are left
//   as they are, since cells at or above the count are never read.
// ----------------------------------------------------------------------------
module sorted_leaf_key_table_core
    import slkt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // key[31:0], payload[63:32], cell_index[67:64], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[1:0], position[6:2], matched[7], key_out[39:8],
    // payload_out[71:40], cell_count[76:72], zero pad
    output logic [M_DATA_W-1:0]      m_tdata
);

    slkt_item_t   in_item;
    slkt_result_t res;
    logic         res_valid;
    logic         res_ready;
    logic         out_valid_reg;
    slkt_result_t out_reg;

    // Unpack the command word
    always_comb begin
        in_item.cmd        = s_tuser;
        in_item.key        = s_tdata[31:0];
        in_item.payload    = s_tdata[63:32];
        in_item.cell_index = s_tdata[67:64];
    end

    slkt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.cell_count, out_reg.payload_out, out_reg.key_out,
                       out_reg.matched, out_reg.position, out_reg.status};

endmodule
`default_nettype wire

// ----- design/slkt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted leaf port checker
// Watches the stream ports of the core and flags broken behavior.
// ----------------------------------------------------------------------------
module slkt_checker
    import slkt_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic [S_DATA_W-1:0] s_tdata,
    input wire logic [1:0]          s_tuser,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // One command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while busy");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == STAT_OK || m_tdata[1:0] == STAT_FULL ||
                      m_tdata[1:0] == STAT_RANGE))
        else $error("undefined status code");

    // Cell count never exceeds the leaf capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (MAX_CELLS > 31) || (32'(m_tdata[76:72]) <= 32'(MAX_CELLS)))
        else $error("cell count above capacity");

    // No result word right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind sorted_leaf_key_table_core slkt_checker u_slkt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- test/tb_sorted_leaf_key_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted leaf key table core testbench
// Sends find, insert, read and unused-code words into the core under random
// gaps and output stalls. Each result word is checked field by field against
// a local copy of the leaf. That copy keeps the cells sorted with the same
// binary search and the same shifting rule. The run starts on an empty leaf,
// fills it with extreme and duplicate keys, then spends most of its words on
// a full leaf.
// ----------------------------------------------------------------------------
module tb_sorted_leaf_key_table_core;
    import slkt_pkg::*;

    // Unused command code; the core answers it as a no-op
    localparam logic [1:0] CMD_NOOP = 2'd3;

    localparam int CLK_HALF     = 4;
    localparam int MAX_IDLE     = 18;
    localparam int RANDOM_WORDS = 1780;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 600000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [1:0]          s_tuser  = 2'd0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Local copy of the leaf
    logic [KEY_W-1:0]   leaf_keys     [MAX_CELLS];
    logic [IN_PL_W-1:0] leaf_payloads [MAX_CELLS];
    int                 leaf_count = 0;

    slkt_result_t pending_results[$];

    int          error_count    = 0;
    int          results_seen   = 0;
    int          cmd_seen[4]    = '{0, 0, 0, 0};
    int          full_refusals  = 0;
    int          range_refusals = 0;
    int          key_hits       = 0;
    int          cycle_count    = 0;
    int          sink_wait      = 0;
    bit          idle_off       = 1'b0;

    sorted_leaf_key_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, pending_results.size());
        $display("FAIL");
        $finish;
    end

    // Draw a wait in cycles; zero while idling is switched off
    function automatic int draw_idle();
        if (idle_off)
            return 0;
        return $urandom_range(0, MAX_IDLE);
    endfunction

    // Binary search over the held cells: matching index or lower bound
    function automatic int leaf_search(input logic [KEY_W-1:0] k, output logic hit);
        int lo;
        int hi;
        int mid;
        hit = 1'b0;
        if (leaf_count == 0)
            return 0;
        lo = 0;
        hi = leaf_count - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (leaf_keys[mid] == k) begin
                hit = 1'b1;
                return mid;
            end else if (leaf_keys[mid] < k) begin
                lo = mid + 1;
            end else begin
                if (mid == 0)
                    return 0;
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    // Apply one command to the local leaf and return the word it must produce
    function automatic slkt_result_t predict_leaf_result(input logic [1:0] cmd,
                                                         input logic [KEY_W-1:0] k,
                                                         input logic [IN_PL_W-1:0] pl,
                                                         input logic [IN_IDX_W-1:0] idx);
        slkt_result_t r;
        int           p;
        int           i;
        logic         hit;
        r = '0;
        case (cmd)
            CMD_FIND, CMD_INSERT: begin
                p = leaf_search(k, hit);
                r.position = p[OUT_POS_W-1:0];
                r.matched  = hit;
                if (hit)
                    key_hits++;
                if (cmd == CMD_INSERT) begin
                    if (leaf_count >= MAX_CELLS) begin
                        r.status = STAT_FULL;
                        full_refusals++;
                    end else begin
                        // Open a slot at p; a duplicate lands ahead of the old cell
                        for (i = leaf_count; i > p; i--) begin
                            leaf_keys[i]     = leaf_keys[i-1];
                            leaf_payloads[i] = leaf_payloads[i-1];
                        end
                        leaf_keys[p]     = k;
                        leaf_payloads[p] = pl;
                        leaf_count++;
                    end
                end
            end
            CMD_READ: begin
                r.position = {1'b0, idx};
                if (int'(idx) < leaf_count) begin
                    r.key_out     = leaf_keys[idx];
                    r.payload_out = leaf_payloads[idx];
                end else begin
                    r.status = STAT_RANGE;
                    range_refusals++;
                end
            end
            default: ;
        endcase
        r.cell_count = leaf_count[OUT_CNT_W-1:0];
        return r;
    endfunction

    // Send one command word, then record the result it must produce
    task automatic send_word(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
                             input logic [IN_PL_W-1:0] pl,
                             input logic [IN_IDX_W-1:0] idx);
        int gap;
        gap = draw_idle();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_DATA_W - IN_IDX_W - IN_PL_W - IN_KEY_W){1'b0}}, idx, pl, k};
        do
            @(posedge aclk);
        while (!s_tready);
        cmd_seen[cmd]++;
        pending_results.push_back(predict_leaf_result(cmd, k, pl, idx));
    endtask

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Check each result word against the oldest expectation
    task automatic check_result(input logic [M_DATA_W-1:0] word);
        slkt_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result word with none expected, expected none, got %h",
                     $time, word);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        compare_field("status",      32'(want.status),      32'(word[1:0]));
        compare_field("position",    32'(want.position),    32'(word[6:2]));
        compare_field("matched",     32'(want.matched),     32'(word[7]));
        compare_field("key_out",     want.key_out,          word[39:8]);
        compare_field("payload_out", want.payload_out,      word[71:40]);
        compare_field("cell_count",  32'(want.cell_count),  32'(word[76:72]));
    endtask

    // Take results and stall the output side at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result(m_tdata);
            sink_wait = draw_idle();
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        m_tready <= aresetn && (sink_wait == 0);
    end

    // Key that often hits or neighbors a held key
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] held;
        held = (leaf_count > 0) ? leaf_keys[$urandom_range(0, leaf_count - 1)] : $urandom();
        case ($urandom_range(0, 9))
            4, 5:    return held;
            6:       return held + 1;
            7:       return held - 1;
            8:       return '0;
            9:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Empty leaf: search, out-of-range reads and the unused code
    task automatic test_empty_leaf();
        send_word(CMD_FIND, 32'h0000_1234, 32'h0, 4'd0);
        send_word(CMD_FIND, 32'h0, 32'h0, 4'd0);
        send_word(CMD_READ, 32'h0, 32'h0, 4'd0);
        send_word(CMD_READ, '1, '1, 4'd15);
        send_word(CMD_NOOP, '1, '1, 4'd15);
        send_word(CMD_NOOP, 32'h0, 32'h0, 4'd0);
    endtask

    // First cells: extreme keys, front and back placement, duplicates
    task automatic test_first_cells();
        int i;
        send_word(CMD_INSERT, 32'h8000_0000, 32'hAAAA_5555, 4'd0);
        send_word(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0);
        send_word(CMD_INSERT, 32'h8000_0000, 32'h5555_AAAA, 4'd0);
        send_word(CMD_INSERT, 32'h0000_0000, 32'h0123_4567, 4'd0);
        send_word(CMD_FIND, 32'h8000_0000, 32'h0, 4'd0);
        send_word(CMD_FIND, 32'h7FFF_FFFF, 32'h0, 4'd0);
        send_word(CMD_FIND, 32'hFFFF_FFFE, 32'h0, 4'd0);
        send_word(CMD_FIND, 32'hFFFF_FFFF, 32'h0, 4'd0);
        for (i = 0; i <= 5; i++)
            send_word(CMD_READ, $urandom(), $urandom(), i[IN_IDX_W-1:0]);
    endtask

    // Random traffic: the leaf fills, then stays full
    task automatic test_random_traffic();
        int          n;
        int unsigned pick;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            // Alternate stretches with and without idling
            if (n % 150 == 0)
                idle_off = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 7)
                send_word(CMD_FIND, pick_key(), $urandom(),
                          IN_IDX_W'($urandom_range(0, 15)));
            else if (pick < 12)
                send_word(CMD_INSERT, pick_key(), $urandom(),
                          IN_IDX_W'($urandom_range(0, 15)));
            else if (pick < 18)
                send_word(CMD_READ, $urandom(), $urandom(),
                          IN_IDX_W'($urandom_range(0, 15)));
            else
                send_word(CMD_NOOP, $urandom(), $urandom(),
                          IN_IDX_W'($urandom_range(0, 15)));
        end
        idle_off = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_leaf();
        test_first_cells();
        test_random_traffic();
        s_tvalid <= 1'b0;

        // Drain, then allow stray words to show up
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d result words: %0d finds, %0d inserts, %0d reads, %0d no-ops.",
                 results_seen, cmd_seen[CMD_FIND], cmd_seen[CMD_INSERT],
                 cmd_seen[CMD_READ], cmd_seen[CMD_NOOP]);
        $display("Leaf held %0d cells; %0d inserts refused full, %0d reads out of range, %0d key hits.",
                 leaf_count, full_refusals, range_refusals, key_hits);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
